/* design/fvdds_pkg.sv */
// package: widths, codes and the sine lookup of the five-voice dds mixer
`timescale 1ns / 1ps

package fvdds_pkg;

    localparam int VOICES_DEF     = 5;
    localparam int TABLE_SIZE_DEF = 256;

    localparam int VOICE_W  = 3;
    localparam int INC_W    = 16;
    localparam int PHASE_W  = 16;
    localparam int SAMPLE_W = 8;
    localparam int SINE_W   = 9;
    localparam int ANGLE_W  = 8;

    localparam int SINE_AMP = 128;
    localparam int RECIP_SH = 17;

    localparam logic MODE_TICK = 1'b0;
    localparam logic MODE_SET  = 1'b1;

    // trunc(128 * sin(k * pi / 128)) for the first quarter turn
    function automatic logic [7:0] quarter_wave(input logic [6:0] k);
        logic [7:0] v;
        case (k)
            7'd0:  v = 8'd0;    7'd1:  v = 8'd3;    7'd2:  v = 8'd6;    7'd3:  v = 8'd9;
            7'd4:  v = 8'd12;   7'd5:  v = 8'd15;   7'd6:  v = 8'd18;   7'd7:  v = 8'd21;
            7'd8:  v = 8'd24;   7'd9:  v = 8'd28;   7'd10: v = 8'd31;   7'd11: v = 8'd34;
            7'd12: v = 8'd37;   7'd13: v = 8'd40;   7'd14: v = 8'd43;   7'd15: v = 8'd46;
            7'd16: v = 8'd48;   7'd17: v = 8'd51;   7'd18: v = 8'd54;   7'd19: v = 8'd57;
            7'd20: v = 8'd60;   7'd21: v = 8'd63;   7'd22: v = 8'd65;   7'd23: v = 8'd68;
            7'd24: v = 8'd71;   7'd25: v = 8'd73;   7'd26: v = 8'd76;   7'd27: v = 8'd78;
            7'd28: v = 8'd81;   7'd29: v = 8'd83;   7'd30: v = 8'd85;   7'd31: v = 8'd88;
            7'd32: v = 8'd90;   7'd33: v = 8'd92;   7'd34: v = 8'd94;   7'd35: v = 8'd96;
            7'd36: v = 8'd98;   7'd37: v = 8'd100;  7'd38: v = 8'd102;  7'd39: v = 8'd104;
            7'd40: v = 8'd106;  7'd41: v = 8'd108;  7'd42: v = 8'd109;  7'd43: v = 8'd111;
            7'd44: v = 8'd112;  7'd45: v = 8'd114;  7'd46: v = 8'd115;  7'd47: v = 8'd117;
            7'd48: v = 8'd118;  7'd49: v = 8'd119;  7'd50: v = 8'd120;  7'd51: v = 8'd121;
            7'd52: v = 8'd122;  7'd53: v = 8'd123;  7'd54: v = 8'd124;  7'd55: v = 8'd124;
            7'd56: v = 8'd125;  7'd57: v = 8'd126;  7'd58: v = 8'd126;  7'd59: v = 8'd127;
            7'd60: v = 8'd127;  7'd61: v = 8'd127;  7'd62: v = 8'd127;  7'd63: v = 8'd127;
            7'd64: v = 8'd128;
            default: v = 8'd0;
        endcase
        return v;
    endfunction

    // signed sine word for an angle in 1/256 turns
    function automatic logic signed [SINE_W-1:0] sine_of_angle(input logic [ANGLE_W-1:0] a);
        logic [7:0] k;
        logic       neg;
        logic [7:0] mag;
        if (a <= 8'd64) begin
            k   = a;
            neg = 1'b0;
        end else if (a <= 8'd128) begin
            k   = 8'd128 - a;
            neg = 1'b0;
        end else if (a <= 8'd192) begin
            k   = a - 8'd128;
            neg = 1'b1;
        end else begin
            k   = 8'(9'd256 - {1'b0, a});
            neg = 1'b1;
        end
        mag = quarter_wave(k[6:0]);
        return neg ? -$signed({1'b0, mag}) : $signed({1'b0, mag});
    endfunction

endpackage

/* design/fvdds_if.sv */
// interfaces: input item channel and result item channel
`timescale 1ns / 1ps

interface fvdds_in_if;
    logic                          valid;
    logic                          ready;
    logic                          mode;
    logic [fvdds_pkg::VOICE_W-1:0] voice;
    logic [fvdds_pkg::INC_W-1:0]   increment;

    modport source (output valid, output mode, output voice, output increment, input ready);
    modport sink   (input valid, input mode, input voice, input increment, output ready);
endinterface

interface fvdds_out_if;
    logic                           valid;
    logic                           ready;
    logic [fvdds_pkg::SAMPLE_W-1:0] sample;
    logic                           silent;

    modport source (output valid, output sample, output silent, input ready);
    modport sink   (input valid, input sample, input silent, output ready);
endinterface

/* design/five_voice_sine_dds_mixer_unit.sv */
// top level: five-voice sine dds tone generator and mixer
`timescale 1ns / 1ps

// Each input item either loads one voice's 16-bit phase increment (mode 1, no result;
// a voice index at or beyond the voice count is ignored) or is a sample tick (mode 0). On a
// tick every phase accumulator advances by its increment, the top phase bits address a
// signed sine lookup, and the voices are summed, divided by the voice count toward zero,
// offset by 128 and clipped to 255. With every increment zero the result is silent with
// sample 0. The block takes one item per cycle unless back-pressure fills the pipeline;
// a tick's result passes through a lookup stage, a sum stage and the divide/offset output
// register, each of which holds under back-pressure while upstream stages drain into it.

module five_voice_sine_dds_mixer_unit #(
    parameter int VOICES     = fvdds_pkg::VOICES_DEF,
    parameter int TABLE_SIZE = fvdds_pkg::TABLE_SIZE_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    fvdds_in_if.sink           i_in,
    fvdds_out_if.source        o_out
);

    localparam int IDX_W   = $clog2(TABLE_SIZE);
    localparam int ANG_W   = (IDX_W > fvdds_pkg::ANGLE_W) ? IDX_W : fvdds_pkg::ANGLE_W;
    localparam int SUM_W   = $clog2(fvdds_pkg::SINE_AMP * VOICES + 1) + 1;
    localparam int MAG_W   = SUM_W - 1;
    localparam int RECIP   = (2 ** fvdds_pkg::RECIP_SH) / VOICES + 1;
    localparam int RECIP_W = $clog2(RECIP + 1);
    localparam int PROD_W  = MAG_W + RECIP_W + 1;
    localparam int SW      = fvdds_pkg::SAMPLE_W;

    logic [fvdds_pkg::PHASE_W-1:0] r_phase [VOICES];
    logic [fvdds_pkg::INC_W-1:0]   r_step  [VOICES];

    logic                                 r_v1, r_v2, r_ov;
    logic signed [fvdds_pkg::SINE_W-1:0]  r_sin [VOICES];
    logic                                 r_sil1, r_sil2;
    logic signed [SUM_W-1:0]              r_sum;
    logic [SW-1:0]                        r_sample;
    logic                                 r_silent;

    logic [fvdds_pkg::PHASE_W-1:0]        n_phase [VOICES];
    logic signed [fvdds_pkg::SINE_W-1:0]  n_sin   [VOICES];
    logic [IDX_W-1:0]                     w_idx   [VOICES];
    logic [ANG_W-1:0]                     w_ext   [VOICES];
    logic                                 n_sil;
    logic signed [SUM_W-1:0]              n_sum;
    logic [SW-1:0]                        n_sample;

    logic              ready1, ready2, ready3;
    logic              tick_acc, set_acc;
    logic              neg;
    logic [MAG_W-1:0]  mag;
    logic [PROD_W-1:0] prod;
    logic [SW-1:0]     quot;
    logic [SW:0]       mix;

    assign ready3 = !r_ov || o_out.ready;
    assign ready2 = !r_v2 || ready3;
    assign ready1 = !r_v1 || ready2;

    assign i_in.ready = ready1;
    assign tick_acc   = i_in.valid && ready1 && (i_in.mode == fvdds_pkg::MODE_TICK);
    assign set_acc    = i_in.valid && ready1 && (i_in.mode == fvdds_pkg::MODE_SET);

    // phase advance and sine lookup
    always_comb begin
        n_sil = 1'b1;
        for (int v = 0; v < VOICES; v++) begin
            n_phase[v] = r_phase[v] + r_step[v];
            w_idx[v]   = n_phase[v][fvdds_pkg::PHASE_W-1 -: IDX_W];
            w_ext[v]   = ANG_W'(w_idx[v]) << (ANG_W - IDX_W);
            n_sin[v]   = fvdds_pkg::sine_of_angle(w_ext[v][ANG_W-1 -: fvdds_pkg::ANGLE_W]);
            if (r_step[v] != '0) begin
                n_sil = 1'b0;
            end
        end
    end

    // mix sum
    always_comb begin
        n_sum = '0;
        for (int v = 0; v < VOICES; v++) begin
            n_sum = n_sum + SUM_W'(r_sin[v]);
        end
    end

    // divide toward zero, offset and clip
    always_comb begin
        neg  = r_sum[SUM_W-1];
        mag  = neg ? MAG_W'(-r_sum) : MAG_W'(r_sum);
        prod = PROD_W'(mag) * PROD_W'(RECIP);
        quot = prod[fvdds_pkg::RECIP_SH +: SW];
        mix  = neg ? ((SW+1)'(fvdds_pkg::SINE_AMP) - {1'b0, quot})
                   : ((SW+1)'(fvdds_pkg::SINE_AMP) + {1'b0, quot});
        if (r_sil2) begin
            n_sample = '0;
        end else if (mix[SW]) begin
            n_sample = '1;
        end else begin
            n_sample = mix[SW-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_ov <= 1'b0;
            for (int v = 0; v < VOICES; v++) begin
                r_phase[v] <= '0;
                r_step[v]  <= '0;
            end
        end else begin
            if (ready1) begin
                r_v1 <= tick_acc;
            end
            if (ready2) begin
                r_v2 <= r_v1;
            end
            if (ready3) begin
                r_ov <= r_v2;
            end
            for (int v = 0; v < VOICES; v++) begin
                if (tick_acc) begin
                    r_phase[v] <= n_phase[v];
                end
                if (set_acc && (32'(i_in.voice) == v)) begin
                    r_step[v] <= i_in.increment;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (ready1) begin
            r_sin  <= n_sin;
            r_sil1 <= n_sil;
        end
        if (ready2) begin
            r_sum  <= n_sum;
            r_sil2 <= r_sil1;
        end
        if (ready3) begin
            r_sample <= n_sample;
            r_silent <= r_sil2;
        end
    end

    assign o_out.valid  = r_ov;
    assign o_out.sample = r_sample;
    assign o_out.silent = r_silent;

endmodule

/* design/fvdds_checker.sv */
// checker: port-level assertions of the dds mixer and its bind
`timescale 1ns / 1ps

module fvdds_checker (
    input logic                           i_clk,
    input logic                           i_rst_n,
    input logic                           i_out_valid,
    input logic                           i_out_ready,
    input logic [fvdds_pkg::SAMPLE_W-1:0] i_out_sample,
    input logic                           i_out_silent
);

    // a waiting result item stays offered
    a_valid_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid)
        else $error("result item dropped while stalled");

    // a waiting result item keeps its payload
    a_payload_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> $stable(i_out_sample) && $stable(i_out_silent))
        else $error("result payload changed while stalled");

    // silent output drives the dac low
    a_silent_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_out_silent |-> i_out_sample == '0)
        else $error("silent item with nonzero sample");

    // reset empties the pipeline
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_out_valid)
        else $error("result item offered after reset");

endmodule

bind five_voice_sine_dds_mixer_unit fvdds_checker u_fvdds_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .i_out_valid  (o_out.valid),
    .i_out_ready  (o_out.ready),
    .i_out_sample (o_out.sample),
    .i_out_silent (o_out.silent)
);

/* tb/five_voice_sine_dds_mixer_unit_tb.sv */
// testbench: directed and random item traffic against a sine mixing predictor, with back-pressure
`timescale 1ns / 1ps

module five_voice_sine_dds_mixer_unit_tb;

    localparam int N_VOICES    = fvdds_pkg::VOICES_DEF;
    localparam int VOICE_W     = fvdds_pkg::VOICE_W;
    localparam int INC_W       = fvdds_pkg::INC_W;
    localparam int PHASE_W     = fvdds_pkg::PHASE_W;
    localparam int SAMPLE_W    = fvdds_pkg::SAMPLE_W;
    localparam int ANGLE_W     = fvdds_pkg::ANGLE_W;
    localparam int HOLD_CYCLES = 300;

    typedef struct packed {
        logic [SAMPLE_W-1:0] sample;
        logic                silent;
    } t_mix_result;

    localparam logic [7:0] QUARTER_SINE [0:64] = '{
        8'd0,   8'd3,   8'd6,   8'd9,   8'd12,  8'd15,  8'd18,  8'd21,
        8'd24,  8'd28,  8'd31,  8'd34,  8'd37,  8'd40,  8'd43,  8'd46,
        8'd48,  8'd51,  8'd54,  8'd57,  8'd60,  8'd63,  8'd65,  8'd68,
        8'd71,  8'd73,  8'd76,  8'd78,  8'd81,  8'd83,  8'd85,  8'd88,
        8'd90,  8'd92,  8'd94,  8'd96,  8'd98,  8'd100, 8'd102, 8'd104,
        8'd106, 8'd108, 8'd109, 8'd111, 8'd112, 8'd114, 8'd115, 8'd117,
        8'd118, 8'd119, 8'd120, 8'd121, 8'd122, 8'd123, 8'd124, 8'd124,
        8'd125, 8'd126, 8'd126, 8'd127, 8'd127, 8'd127, 8'd127, 8'd127,
        8'd128
    };

    logic i_clk = 1'b0;
    logic i_rst_n;

    fvdds_in_if  in_ch ();
    fvdds_out_if out_ch ();

    five_voice_sine_dds_mixer_unit dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_ch.sink),
        .o_out   (out_ch.source)
    );

    always #2 i_clk = ~i_clk;

    logic [PHASE_W-1:0] voice_phase [N_VOICES];
    logic [INC_W-1:0]   voice_step  [N_VOICES];
    t_mix_result        expected_mix_q [$];

    int send_idle_pct;
    int recv_stall_pct;
    int hold_left;
    bit hold_kick;
    bit hold_seen;
    int mismatch_count = 0;
    int items_sent;
    int ticks_sent;
    int results_checked = 0;
    int silent_expected;
    int clipped_expected;

    // receiver ready, with an optional long hold-off
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            out_ch.ready <= 1'b0;
        end else if (hold_left != 0) begin
            out_ch.ready <= 1'b0;
        end else begin
            out_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    // long receiver hold-off, counted in cycles
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            hold_left <= 0;
            hold_seen <= 1'b0;
        end else if (hold_kick != hold_seen) begin
            hold_left <= HOLD_CYCLES;
            hold_seen <= hold_kick;
        end else if (hold_left != 0) begin
            hold_left <= hold_left - 1;
        end
    end

    function automatic int sine_word(input logic [ANGLE_W-1:0] angle);
        int a;
        a = angle;
        if (a <= 64) begin
            return QUARTER_SINE[a];
        end else if (a <= 128) begin
            return QUARTER_SINE[128 - a];
        end else if (a <= 192) begin
            return -int'(QUARTER_SINE[a - 128]);
        end
        return -int'(QUARTER_SINE[256 - a]);
    endfunction

    task automatic mix_predict(input logic mode, input logic [VOICE_W-1:0] voice,
                               input logic [INC_W-1:0] inc);
        int          sum;
        int          avg;
        int          v;
        bit          quiet;
        t_mix_result r;
        if (mode == fvdds_pkg::MODE_SET) begin
            if (voice < N_VOICES) begin
                voice_step[voice] = inc;
            end
            return;
        end
        sum   = 0;
        quiet = 1'b1;
        for (v = 0; v < N_VOICES; v++) begin
            voice_phase[v] = voice_phase[v] + voice_step[v];
            sum += sine_word(voice_phase[v][PHASE_W-1 -: ANGLE_W]);
            if (voice_step[v] != '0) begin
                quiet = 1'b0;
            end
        end
        if (quiet) begin
            r = '{sample: '0, silent: 1'b1};
            silent_expected++;
        end else begin
            avg = sum / N_VOICES + fvdds_pkg::SINE_AMP;
            if (avg > 255) begin
                avg = 255;
                clipped_expected++;
            end
            if (avg < 0) begin
                avg = 0;
            end
            r = '{sample: avg[SAMPLE_W-1:0], silent: 1'b0};
        end
        expected_mix_q.push_back(r);
        ticks_sent++;
    endtask

    task automatic report_mismatch(input string what, input int got, input int want);
        $display("mismatch on %s: got %0d, expected %0d (t=%0t)", what, got, want, $realtime);
        mismatch_count++;
    endtask

    always @(posedge i_clk) begin
        t_mix_result want;
        if (i_rst_n && out_ch.valid && out_ch.ready) begin
            if (expected_mix_q.size() == 0) begin
                report_mismatch("unexpected result, sample", out_ch.sample, -1);
            end else begin
                want = expected_mix_q.pop_front();
                if (out_ch.sample !== want.sample) begin
                    report_mismatch("sample", out_ch.sample, want.sample);
                end
                if (out_ch.silent !== want.silent) begin
                    report_mismatch("silent", out_ch.silent, want.silent);
                end
                results_checked++;
            end
        end
    end

    task automatic send_item(input logic mode, input logic [VOICE_W-1:0] voice,
                             input logic [INC_W-1:0] inc);
        while ($urandom_range(99) < send_idle_pct) begin
            in_ch.valid <= 1'b0;
            @(posedge i_clk);
        end
        in_ch.valid     <= 1'b1;
        in_ch.mode      <= mode;
        in_ch.voice     <= voice;
        in_ch.increment <= inc;
        @(posedge i_clk);
        while (!in_ch.ready) begin
            @(posedge i_clk);
        end
        mix_predict(mode, voice, inc);
        items_sent++;
    endtask

    task automatic set_all_steps(input logic [INC_W-1:0] inc);
        int v;
        for (v = 0; v < N_VOICES; v++) begin
            send_item(fvdds_pkg::MODE_SET, v[VOICE_W-1:0], inc);
        end
    endtask

    task automatic set_traffic(input int idle_pct, input int stall_pct);
        send_idle_pct  = idle_pct;
        recv_stall_pct = stall_pct;
    endtask

    task automatic test_silence_after_reset();
        int v;
        send_item(fvdds_pkg::MODE_TICK, '0, '0);
        for (v = N_VOICES; v < 8; v++) begin
            send_item(fvdds_pkg::MODE_SET, v[VOICE_W-1:0], '1);
        end
        send_item(fvdds_pkg::MODE_TICK, '1, '1);
    endtask

    task automatic test_mix_extremes();
        // quarter turn on every voice clips high, three quarters bottoms out
        set_all_steps(16'h4000);
        send_item(fvdds_pkg::MODE_TICK, '0, '0);
        set_all_steps(16'h8000);
        send_item(fvdds_pkg::MODE_TICK, '0, '0);
        send_item(fvdds_pkg::MODE_SET, '0, 16'hFFFF);
        send_item(fvdds_pkg::MODE_TICK, '0, '0);
    endtask

    task automatic test_silence_with_phase();
        set_all_steps('0);
        send_item(fvdds_pkg::MODE_TICK, '0, '0);
    endtask

    task automatic random_item();
        int                 pick;
        int                 sel;
        logic [INC_W-1:0]   inc;
        pick = $urandom_range(99);
        if (pick < 3) begin
            set_all_steps('0);
            send_item(fvdds_pkg::MODE_TICK, VOICE_W'($urandom_range(7)), INC_W'($urandom));
        end else if (pick < 48) begin
            send_item(fvdds_pkg::MODE_TICK, VOICE_W'($urandom_range(7)), INC_W'($urandom));
        end else if (pick < 54) begin
            send_item(fvdds_pkg::MODE_SET, VOICE_W'($urandom_range(7, N_VOICES)),
                      INC_W'($urandom));
        end else begin
            sel = $urandom_range(9);
            case (sel)
                0:       inc = '0;
                1:       inc = '1;
                2, 3, 4: inc = INC_W'($urandom_range(512, 1));
                default: inc = INC_W'($urandom);
            endcase
            send_item(fvdds_pkg::MODE_SET, VOICE_W'($urandom_range(N_VOICES - 1)), inc);
        end
    endtask

    task automatic test_random_traffic(input int n, input int idle_pct, input int stall_pct);
        set_traffic(idle_pct, stall_pct);
        repeat (n) random_item();
    endtask

    task automatic test_backpressure();
        set_traffic(0, 0);
        while (hold_left != 0) begin
            @(posedge i_clk);
        end
        hold_kick = !hold_kick;
        set_all_steps(INC_W'($urandom));
        repeat (40) send_item(fvdds_pkg::MODE_TICK, VOICE_W'($urandom_range(7)),
                              INC_W'($urandom));
    endtask

    task automatic drain();
        in_ch.valid <= 1'b0;
        set_traffic(0, 0);
        while (expected_mix_q.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (10) @(posedge i_clk);
    endtask

    initial begin
        int v;
        i_rst_n         = 1'b0;
        in_ch.valid     = 1'b0;
        in_ch.mode      = fvdds_pkg::MODE_TICK;
        in_ch.voice     = '0;
        in_ch.increment = '0;
        send_idle_pct   = 0;
        recv_stall_pct  = 0;
        hold_kick       = 1'b0;
        items_sent      = 0;
        ticks_sent      = 0;
        silent_expected = 0;
        clipped_expected = 0;
        for (v = 0; v < N_VOICES; v++) begin
            voice_phase[v] = '0;
            voice_step[v]  = '0;
        end
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_silence_after_reset();
        test_mix_extremes();
        test_silence_with_phase();
        test_random_traffic(90, 0, 0);
        test_random_traffic(80, 88, 0);
        test_random_traffic(80, 0, 88);
        test_backpressure();
        test_random_traffic(90, 10, 10);
        drain();

        $display("covered %0d items: %0d ticks checked against %0d results", items_sent,
                 ticks_sent, results_checked);
        $display("silent ticks %0d, clipped mixes %0d, with idle, stall and hold-off phases",
                 silent_expected, clipped_expected);
        if (mismatch_count == 0) begin
            $display("five_voice_sine_dds_mixer_unit regression: pass");
        end else begin
            $display("five_voice_sine_dds_mixer_unit regression: fail");
        end
        $finish;
    end

    initial begin
        #2_000_000;
        $display("timeout with %0d results outstanding", expected_mix_q.size());
        $display("five_voice_sine_dds_mixer_unit regression: fail");
        $finish;
    end

endmodule

/* sim.f */
design/fvdds_pkg.sv
design/fvdds_if.sv
design/five_voice_sine_dds_mixer_unit.sv
design/fvdds_checker.sv
tb/five_voice_sine_dds_mixer_unit_tb.sv
